>>> rtl/gtpg_pkg.sv
// ----------------------------------------------------------------------------
// Glyph text pixel generator package
// Font geometry, code range, queue depth and the 5x7 glyph ROM.
// ----------------------------------------------------------------------------
package gtpg_pkg;

   localparam int COORD_BITS_DEFAULT = 16;
   localparam int GLYPH_W            = 5;
   localparam int GLYPH_H            = 7;
   localparam int GLYPH_BITS         = GLYPH_W * GLYPH_H;
   localparam int GLYPH_ADV          = 6;
   localparam int CODE_BITS          = 16;
   localparam int FIELD_BITS         = 16;
   localparam int COLOR_BITS         = 24;
   localparam int GLYPH_IDX_BITS     = 6;
   localparam int QUEUE_DEPTH        = 2;

   localparam logic [CODE_BITS-1:0] FIRST_CODE = 16'd32;
   localparam logic [CODE_BITS-1:0] END_CODE   = 16'd96;
   localparam logic [CODE_BITS-1:0] LOWER_A    = 16'd97;
   localparam logic [CODE_BITS-1:0] LOWER_Z    = 16'd122;
   localparam logic [CODE_BITS-1:0] CASE_DIFF  = 16'd32;

   // Row 0 in the top bits, leftmost column first.
   function automatic logic [GLYPH_BITS-1:0] glyph_mask(input logic [GLYPH_IDX_BITS-1:0] gi);
      logic [GLYPH_BITS-1:0] m;
      case (gi)
         6'd1:  m = {5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h00, 5'h04};
         6'd12: m = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h04, 5'h08};
         6'd13: m = {5'h00, 5'h00, 5'h00, 5'h1F, 5'h00, 5'h00, 5'h00};
         6'd14: m = {5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h04, 5'h00};
         6'd16: m = {5'h0E, 5'h11, 5'h13, 5'h15, 5'h19, 5'h11, 5'h0E};
         6'd17: m = {5'h04, 5'h0C, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
         6'd18: m = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h08, 5'h1F};
         6'd19: m = {5'h1F, 5'h02, 5'h04, 5'h02, 5'h01, 5'h11, 5'h0E};
         6'd20: m = {5'h02, 5'h06, 5'h0A, 5'h12, 5'h1F, 5'h02, 5'h02};
         6'd21: m = {5'h1F, 5'h10, 5'h1E, 5'h01, 5'h01, 5'h11, 5'h0E};
         6'd22: m = {5'h06, 5'h08, 5'h10, 5'h1E, 5'h11, 5'h11, 5'h0E};
         6'd23: m = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h08, 5'h08};
         6'd24: m = {5'h0E, 5'h11, 5'h11, 5'h0E, 5'h11, 5'h11, 5'h0E};
         6'd25: m = {5'h0E, 5'h11, 5'h11, 5'h0F, 5'h01, 5'h02, 5'h0C};
         6'd26: m = {5'h00, 5'h04, 5'h04, 5'h00, 5'h04, 5'h04, 5'h00};
         6'd31: m = {5'h0E, 5'h11, 5'h01, 5'h02, 5'h04, 5'h00, 5'h04};
         6'd33: m = {5'h0E, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
         6'd34: m = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h11, 5'h11, 5'h1E};
         6'd35: m = {5'h0E, 5'h11, 5'h10, 5'h10, 5'h10, 5'h11, 5'h0E};
         6'd36: m = {5'h1C, 5'h12, 5'h11, 5'h11, 5'h11, 5'h12, 5'h1C};
         6'd37: m = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h1F};
         6'd38: m = {5'h1F, 5'h10, 5'h10, 5'h1E, 5'h10, 5'h10, 5'h10};
         6'd39: m = {5'h0E, 5'h11, 5'h10, 5'h17, 5'h11, 5'h11, 5'h0F};
         6'd40: m = {5'h11, 5'h11, 5'h11, 5'h1F, 5'h11, 5'h11, 5'h11};
         6'd41: m = {5'h0E, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h0E};
         6'd42: m = {5'h07, 5'h02, 5'h02, 5'h02, 5'h02, 5'h12, 5'h0C};
         6'd43: m = {5'h11, 5'h12, 5'h14, 5'h18, 5'h14, 5'h12, 5'h11};
         6'd44: m = {5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h10, 5'h1F};
         6'd45: m = {5'h11, 5'h1B, 5'h15, 5'h15, 5'h11, 5'h11, 5'h11};
         6'd46: m = {5'h11, 5'h19, 5'h15, 5'h13, 5'h11, 5'h11, 5'h11};
         6'd47: m = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
         6'd48: m = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h10, 5'h10, 5'h10};
         6'd49: m = {5'h0E, 5'h11, 5'h11, 5'h11, 5'h15, 5'h12, 5'h0D};
         6'd50: m = {5'h1E, 5'h11, 5'h11, 5'h1E, 5'h14, 5'h12, 5'h11};
         6'd51: m = {5'h0F, 5'h10, 5'h10, 5'h0E, 5'h01, 5'h01, 5'h1E};
         6'd52: m = {5'h1F, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04, 5'h04};
         6'd53: m = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0E};
         6'd54: m = {5'h11, 5'h11, 5'h11, 5'h11, 5'h11, 5'h0A, 5'h04};
         6'd55: m = {5'h11, 5'h11, 5'h11, 5'h15, 5'h15, 5'h1B, 5'h11};
         6'd56: m = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h0A, 5'h11, 5'h11};
         6'd57: m = {5'h11, 5'h11, 5'h0A, 5'h04, 5'h04, 5'h04, 5'h04};
         6'd58: m = {5'h1F, 5'h01, 5'h02, 5'h04, 5'h08, 5'h10, 5'h1F};
         default: m = '0;
      endcase
      return m;
   endfunction

endpackage

>>> rtl/gtpg_front.sv
// ----------------------------------------------------------------------------
// Glyph text pixel generator front end
// Accepts code units, folds case, looks up the glyph and keeps the pen.
// ----------------------------------------------------------------------------
module gtpg_front
   import gtpg_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT,
   parameter int JOB_BITS   = GLYPH_BITS + 2 * COORD_BITS + COLOR_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  logic [CODE_BITS-1:0]  code_unit,
   input  logic                  first_of_string,
   input  logic [FIELD_BITS-1:0] start_x,
   input  logic [FIELD_BITS-1:0] baseline_y,
   input  logic [COLOR_BITS-1:0] text_color,
   output logic                  push,
   output logic [JOB_BITS-1:0]   push_job,
   input  logic                  queue_full
);

   logic [COORD_BITS-1:0]     pen_ff, pen_in;
   logic [COORD_BITS-1:0]     pen_base;
   logic [COORD_BITS-1:0]     top;
   logic [CODE_BITS-1:0]      code_fold;
   logic [CODE_BITS-1:0]      code_off;
   logic                      covered;
   logic                      accept;
   logic [GLYPH_BITS-1:0]     mask;

   assign req_tready = !queue_full;
   assign accept     = req_tvalid && req_tready;

   always_comb begin
      code_fold = code_unit;
      if (code_unit >= LOWER_A && code_unit <= LOWER_Z) begin
         code_fold = code_unit - CASE_DIFF;
      end
   end

   assign covered  = (code_fold >= FIRST_CODE) && (code_fold < END_CODE);
   assign code_off = code_fold - FIRST_CODE;
   assign mask     = glyph_mask(code_off[GLYPH_IDX_BITS-1:0]);

   assign pen_base = first_of_string ? COORD_BITS'(signed'(start_x)) : pen_ff;
   assign top      = COORD_BITS'(signed'(baseline_y)) - COORD_BITS'(GLYPH_H);

   always_comb begin
      pen_in = pen_ff;
      if (accept) begin
         pen_in = covered ? pen_base + COORD_BITS'(GLYPH_ADV) : pen_base;
      end
   end

   // blank glyphs only move the pen
   assign push     = accept && covered && (mask != '0);
   assign push_job = {text_color, top, pen_base, mask};

   always_ff @(posedge clock) begin
      if (reset) begin
         pen_ff <= '0;
      end else begin
         pen_ff <= pen_in;
      end
   end

endmodule

>>> rtl/gtpg_fifo.sv
// ----------------------------------------------------------------------------
// Glyph text pixel generator job queue
// Short register queue between the front end and the pixel scanner.
// ----------------------------------------------------------------------------
module gtpg_fifo
   import gtpg_pkg::*;
#(
   parameter int DATA_BITS = 8
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 push,
   input  logic [DATA_BITS-1:0] push_data,
   output logic                 full,
   input  logic                 pop,
   output logic [DATA_BITS-1:0] pop_data,
   output logic                 empty
);

   localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

   logic [DATA_BITS-1:0] mem_ff [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]  wr_ptr_ff, wr_ptr_in;
   logic [PTR_BITS-1:0]  rd_ptr_ff, rd_ptr_in;
   logic [CNT_BITS-1:0]  count_ff, count_in;
   logic                 do_push, do_pop;

   assign full     = (count_ff == CNT_BITS'(QUEUE_DEPTH));
   assign empty    = (count_ff == '0);
   assign do_push  = push && !full;
   assign do_pop   = pop && !empty;
   assign pop_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

>>> rtl/gtpg_back.sv
// ----------------------------------------------------------------------------
// Glyph text pixel generator pixel scanner
// Walks one glyph bit per cycle while the output is free; registers a beat per lit pixel.
// ----------------------------------------------------------------------------
module gtpg_back
   import gtpg_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT,
   parameter int JOB_BITS   = GLYPH_BITS + 2 * COORD_BITS + COLOR_BITS
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  queue_empty,
   input  logic [JOB_BITS-1:0]   pop_job,
   output logic                  pop,
   output logic                  rsp_tvalid,
   input  logic                  rsp_tready,
   output logic [FIELD_BITS-1:0] pixel_x,
   output logic [FIELD_BITS-1:0] pixel_y,
   output logic [COLOR_BITS-1:0] pixel_color,
   output logic                  last_of_glyph
);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_SCAN = 2'b10
   } state_type;

   state_type             state_ff, state_in;
   logic [GLYPH_BITS-1:0] mask_ff, mask_in;
   logic [2:0]            row_ff, row_in;
   logic [2:0]            col_ff, col_in;
   logic [COORD_BITS-1:0] pen_ff, pen_in;
   logic [COORD_BITS-1:0] top_ff, top_in;
   logic [COLOR_BITS-1:0] color_ff, color_in;

   logic                  out_valid_ff, out_valid_in;
   logic [FIELD_BITS-1:0] out_x_ff, out_x_in;
   logic [FIELD_BITS-1:0] out_y_ff, out_y_in;
   logic [COLOR_BITS-1:0] out_color_ff, out_color_in;
   logic                  out_last_ff, out_last_in;

   logic                  out_free;
   logic                  rest_empty;
   logic [COORD_BITS-1:0] sum_x, sum_y;

   assign out_free   = !out_valid_ff || rsp_tready;
   assign rest_empty = (mask_ff[GLYPH_BITS-2:0] == '0);
   assign sum_x      = pen_ff + COORD_BITS'(col_ff);
   assign sum_y      = top_ff + COORD_BITS'(row_ff);
   assign pop        = (state_ff == ST_IDLE) && !queue_empty;

   always_comb begin
      state_in     = state_ff;
      mask_in      = mask_ff;
      row_in       = row_ff;
      col_in       = col_ff;
      pen_in       = pen_ff;
      top_in       = top_ff;
      color_in     = color_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_x_in     = out_x_ff;
      out_y_in     = out_y_ff;
      out_color_in = out_color_ff;
      out_last_in  = out_last_ff;
      case (state_ff)
         ST_IDLE: begin
            if (!queue_empty) begin
               {color_in, top_in, pen_in, mask_in} = pop_job;
               row_in   = '0;
               col_in   = '0;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (out_free) begin
               if (mask_ff[GLYPH_BITS-1]) begin
                  out_valid_in = 1'b1;
                  out_x_in     = FIELD_BITS'(sum_x);
                  out_y_in     = FIELD_BITS'(sum_y);
                  out_color_in = color_ff;
                  out_last_in  = rest_empty;
               end
               mask_in = mask_ff << 1;
               if (col_ff == 3'(GLYPH_W - 1)) begin
                  col_in = '0;
                  row_in = row_ff + 1'b1;
               end else begin
                  col_in = col_ff + 1'b1;
               end
               if (rest_empty) begin
                  state_in = ST_IDLE;
               end
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      mask_ff      <= mask_in;
      row_ff       <= row_in;
      col_ff       <= col_in;
      pen_ff       <= pen_in;
      top_ff       <= top_in;
      color_ff     <= color_in;
      out_x_ff     <= out_x_in;
      out_y_ff     <= out_y_in;
      out_color_ff <= out_color_in;
      out_last_ff  <= out_last_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
   end

   assign rsp_tvalid    = out_valid_ff;
   assign pixel_x       = out_x_ff;
   assign pixel_y       = out_y_ff;
   assign pixel_color   = out_color_ff;
   assign last_of_glyph = out_last_ff;

endmodule

>>> rtl/glyph_text_pixel_generator.sv
// ----------------------------------------------------------------------------
// Glyph text pixel generator
// Draws text code units with a 5x7 font as a stream of lit pixel beats.
//
//   group  dir  tdata (low bit up)                                tuser / tlast
//   req_   in   code_unit, start_x, baseline_y, text_color (72b)  tuser: first_of_string
//   rsp_   out  pixel_x, pixel_y, pixel_color (56b)               tlast: last_of_glyph
//
// A glyph is loaded from the queue, then scanned one bit per cycle while the
// output register is free, row by row, stopping after the last lit pixel.
// Uncovered and blank codes only touch the pen and never enter the queue.
// A 2-entry job queue lets the input side run ahead of the scanner.
// The scanner stalls while the output register holds an untaken beat.
// Reset clears the pen to zero and empties queue and output.
// ----------------------------------------------------------------------------
module glyph_text_pixel_generator
   import gtpg_pkg::*;
#(
   parameter int COORD_BITS = COORD_BITS_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [71:0] req_tdata,   // code_unit, start_x, baseline_y, text_color
   input  logic        req_tuser,   // first_of_string
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [55:0] rsp_tdata,   // pixel_x, pixel_y, pixel_color
   output logic        rsp_tlast    // last_of_glyph
);

   localparam int JOB_BITS = GLYPH_BITS + 2 * COORD_BITS + COLOR_BITS;

   logic                  push, pop, queue_full, queue_empty;
   logic [JOB_BITS-1:0]   push_job, pop_job;
   logic [FIELD_BITS-1:0] pixel_x, pixel_y;
   logic [COLOR_BITS-1:0] pixel_color;

   gtpg_front #(
      .COORD_BITS (COORD_BITS),
      .JOB_BITS   (JOB_BITS)
   ) u_front (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .code_unit       (req_tdata[15:0]),
      .first_of_string (req_tuser),
      .start_x         (req_tdata[31:16]),
      .baseline_y      (req_tdata[47:32]),
      .text_color      (req_tdata[71:48]),
      .push            (push),
      .push_job        (push_job),
      .queue_full      (queue_full)
   );

   gtpg_fifo #(
      .DATA_BITS (JOB_BITS)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_data (push_job),
      .full      (queue_full),
      .pop       (pop),
      .pop_data  (pop_job),
      .empty     (queue_empty)
   );

   gtpg_back #(
      .COORD_BITS (COORD_BITS),
      .JOB_BITS   (JOB_BITS)
   ) u_back (
      .clock         (clock),
      .reset         (reset),
      .queue_empty   (queue_empty),
      .pop_job       (pop_job),
      .pop           (pop),
      .rsp_tvalid    (rsp_tvalid),
      .rsp_tready    (rsp_tready),
      .pixel_x       (pixel_x),
      .pixel_y       (pixel_y),
      .pixel_color   (pixel_color),
      .last_of_glyph (rsp_tlast)
   );

   assign rsp_tdata = {pixel_color, pixel_y, pixel_x};

endmodule
